// File: rtl/gwm_pkg.sv
// gwm_pkg: shared constants, types and functions of the glob wildcard matcher
// used by gwm_pattern_regs and glob_wildcard_matcher; depends on nothing

package gwm_pkg;

  // pattern geometry
  localparam int PATTERN_MAX    = 32;
  localparam int SET_W          = PATTERN_MAX + 1;
  localparam int LEN_W          = $clog2(PATTERN_MAX + 1);
  localparam int BYTES_PER_WORD = 8;
  localparam int WORD_COUNT     = 4;
  localparam int WORD_W         = 64;
  localparam int CHAR_W         = 8;
  localparam int CFG_INDEX_W    = 3;

  // special characters
  localparam logic [CHAR_W-1:0] STAR_CHAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] QMARK_CHAR = 8'h3F;
  localparam logic [CHAR_W-1:0] UPPER_A    = 8'h41;
  localparam logic [CHAR_W-1:0] UPPER_Z    = 8'h5A;
  localparam logic [CHAR_W-1:0] LOWER_A    = 8'h61;

  // position set after reset and after each name: only the start position
  localparam logic [SET_W-1:0] SET_INIT = SET_W'(1);

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_WORD_0 = 3'd0,
    REG_PATTERN_WORD_1 = 3'd1,
    REG_PATTERN_WORD_2 = 3'd2,
    REG_PATTERN_WORD_3 = 3'd3,
    REG_PATTERN_LENGTH = 3'd4
  } cfg_reg_t;

  // decoded pattern, one bit or byte per pattern position
  typedef struct packed {
    logic [PATTERN_MAX-1:0]             live;
    logic [PATTERN_MAX-1:0]             star;
    logic [PATTERN_MAX-1:0]             qmark;
    logic [PATTERN_MAX-1:0][CHAR_W-1:0] folded;
    logic [LEN_W-1:0]                   len;
  } pattern_info_t;

  // ascii upper case to lower case
  function automatic logic [CHAR_W-1:0] fold_byte(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c >= UPPER_A && c <= UPPER_Z) begin
      r = c - UPPER_A + LOWER_A;
    end
    return r;
  endfunction

  // a star at a live position also enables the next position (empty run);
  // runs of stars behave like a carry chain: star propagates, live star generates
  function automatic logic [SET_W-1:0] star_closure(input logic [SET_W-1:0] s,
                                                     input logic [PATTERN_MAX-1:0] star);
    logic [SET_W-1:0] prop;
    logic [SET_W-1:0] gen;
    logic [SET_W:0]   sum;
    logic [SET_W:0]   carry;
    prop  = {1'b0, star};
    gen   = s & prop;
    sum   = {1'b0, prop} + {1'b0, gen};
    carry = sum ^ {1'b0, prop} ^ {1'b0, gen};
    return s | carry[SET_W-1:0];
  endfunction

endpackage

// File: rtl/gwm_pattern_regs.sv
// gwm_pattern_regs: pattern configuration registers and per-position decode
// depends on gwm_pkg

module gwm_pattern_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_en,
  input  logic [gwm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gwm_pkg::WORD_W-1:0]      cfg_data,
  output gwm_pkg::pattern_info_t          pat
);

  logic [gwm_pkg::WORD_COUNT-1:0][gwm_pkg::WORD_W-1:0] pattern_word;
  logic [gwm_pkg::LEN_W-1:0]                           pattern_length;
  logic [gwm_pkg::LEN_W-1:0]                           len_used;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_word   <= '0;
      pattern_length <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        gwm_pkg::REG_PATTERN_WORD_0: pattern_word[0] <= cfg_data;
        gwm_pkg::REG_PATTERN_WORD_1: pattern_word[1] <= cfg_data;
        gwm_pkg::REG_PATTERN_WORD_2: pattern_word[2] <= cfg_data;
        gwm_pkg::REG_PATTERN_WORD_3: pattern_word[3] <= cfg_data;
        gwm_pkg::REG_PATTERN_LENGTH: pattern_length <= cfg_data[gwm_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // length saturates at the pattern capacity
  assign len_used = (pattern_length > gwm_pkg::LEN_W'(gwm_pkg::PATTERN_MAX)) ?
                    gwm_pkg::LEN_W'(gwm_pkg::PATTERN_MAX) : pattern_length;

  // per-position decode
  always_comb begin
    logic [gwm_pkg::CHAR_W-1:0] b;
    pat     = '0;
    pat.len = len_used;
    for (int j = 0; j < gwm_pkg::PATTERN_MAX; j++) begin
      b = pattern_word[j / gwm_pkg::BYTES_PER_WORD]
                      [(j % gwm_pkg::BYTES_PER_WORD) * gwm_pkg::CHAR_W +: gwm_pkg::CHAR_W];
      pat.live[j]   = gwm_pkg::LEN_W'(j) < len_used;
      pat.star[j]   = pat.live[j] && (b == gwm_pkg::STAR_CHAR);
      pat.qmark[j]  = pat.live[j] && (b == gwm_pkg::QMARK_CHAR);
      pat.folded[j] = gwm_pkg::fold_byte(b);
    end
  end

endmodule

// File: rtl/glob_wildcard_matcher.sv
// glob_wildcard_matcher: top level of the streamed glob name matcher
// depends on gwm_pkg and gwm_pattern_regs
//
// Usage: the pattern (up to 32 bytes, '*' any run, '?' any one byte, other
// bytes compared with A-Z folded to lower case) and its length are written
// through the cfg_write_en / cfg_index / cfg_data port while no name is open.
// A file name then streams in on the in_valid / in_ready channel, one byte
// per item in name_char with has_char set; the item with last set closes the
// name (has_char low with last set tests the empty name, and has_char low
// without last is an idle item). For each last item one result, matched,
// leaves on the out_valid / out_ready channel.
// Throughput: one item per cycle, sustained while the result path is not stalled.
// Path of a last item: input register, position-set update into the middle
// stage, then star closure and length select into the result register.
// Reset clears the pattern, the length and the position set; the set also
// returns to the start position after each last item. When the receiver
// stalls, one result waits in the output register and one more in the
// middle stage; in_ready drops only once a further last item then sits in
// the input register.

module glob_wildcard_matcher (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_en,
  input  logic [gwm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gwm_pkg::WORD_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [gwm_pkg::CHAR_W-1:0]      name_char,
  input  logic                            has_char,
  input  logic                            last,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            matched
);

  gwm_pkg::pattern_info_t pat;

  logic                          in_valid_q;
  logic [gwm_pkg::CHAR_W-1:0]    in_char_q;
  logic                          in_has_q;
  logic                          in_last_q;

  logic [gwm_pkg::SET_W-1:0]     active_positions;
  logic                          mid_valid;
  logic [gwm_pkg::SET_W-1:0]     mid_set;

  logic                          out_take;
  logic                          mid_free;
  logic                          in_move;
  logic                          in_free;

  logic [gwm_pkg::SET_W-1:0]     closed;
  logic [gwm_pkg::SET_W-1:0]     final_closed;
  logic [gwm_pkg::PATTERN_MAX-1:0] hit;
  logic [gwm_pkg::CHAR_W-1:0]    fc;
  logic [gwm_pkg::SET_W-1:0]     next_set;
  logic [gwm_pkg::SET_W-1:0]     step_set;

  // pattern registers
  gwm_pattern_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pat          (pat)
  );

  // stage flow control: only last items occupy the later stages
  assign out_take = !out_valid || out_ready;
  assign mid_free = !mid_valid || out_take;
  assign in_move  = in_valid_q && (!in_last_q || mid_free);
  assign in_free  = !in_valid_q || in_move;
  assign in_ready = in_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (in_free) begin
      in_valid_q <= in_valid;
    end
    if (in_valid && in_ready) begin
      in_char_q <= name_char;
      in_has_q  <= has_char;
      in_last_q <= last;
    end
  end

  // position set update for one name byte
  always_comb begin
    fc     = gwm_pkg::fold_byte(in_char_q);
    closed = gwm_pkg::star_closure(active_positions, pat.star);
    for (int j = 0; j < gwm_pkg::PATTERN_MAX; j++) begin
      hit[j] = pat.live[j] && !pat.star[j] && (pat.qmark[j] || (pat.folded[j] == fc));
    end
    next_set = {1'b0, closed[gwm_pkg::PATTERN_MAX-1:0] & pat.star} |
               {closed[gwm_pkg::PATTERN_MAX-1:0] & hit, 1'b0};
    step_set = in_has_q ? next_set : active_positions;
  end

  // live set, back to start after each name
  always_ff @(posedge clk) begin
    if (rst) begin
      active_positions <= gwm_pkg::SET_INIT;
    end else if (in_move) begin
      active_positions <= in_last_q ? gwm_pkg::SET_INIT : step_set;
    end
  end

  // middle stage holds the final set of a name
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (mid_free) begin
      mid_valid <= in_move && in_last_q;
    end
    if (mid_free && in_move && in_last_q) begin
      mid_set <= step_set;
    end
  end

  // closure of the final set, then the bit at the pattern length
  assign final_closed = gwm_pkg::star_closure(mid_set, pat.star);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= mid_valid;
    end
    if (out_take && mid_valid) begin
      matched <= final_closed[pat.len];
    end
  end

  // checks
  a_set_restart: assert property (@(posedge clk) disable iff (rst)
    in_move && in_last_q |=> active_positions == gwm_pkg::SET_INIT)
    else $error("position set not restarted after last item");

  a_mid_load: assert property (@(posedge clk) disable iff (rst)
    in_move && in_last_q |=> mid_valid)
    else $error("last item lost before middle stage");

  a_mid_hold: assert property (@(posedge clk) disable iff (rst)
    mid_valid && !out_take |=> mid_valid && $stable(mid_set))
    else $error("middle stage changed while stalled");

  a_last_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid_q && in_last_q && !mid_free |=> in_valid_q && $stable(active_positions))
    else $error("stalled last item dropped or set changed");

  a_reset_set: assert property (@(posedge clk)
    rst |=> active_positions == gwm_pkg::SET_INIT && !out_valid && !mid_valid)
    else $error("reset state wrong");

endmodule
